// ===== rtl/core/pdip_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pdip_pkg
// Shared types and constants of the PIR database inner product block.
// ----------------------------------------------------------------------------
package pdip_pkg;

   localparam int DATA_W     = 64;
   localparam int HALF_W     = 32;
   localparam int REC_IDX_W  = 10;
   localparam int WORD_IDX_W = 3;
   localparam int DOMAIN_W   = 4;
   localparam int EFF_W      = 5;

   localparam logic [DOMAIN_W-1:0] DOMAIN_RESET = 4'd10;

   localparam logic KIND_LOAD = 1'b0;
   localparam logic KIND_COEF = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FETCH,
      ST_MUL_LO,
      ST_MUL_XA,
      ST_MUL_XB,
      ST_WRITE_BACK,
      ST_EMIT_RD,
      ST_EMIT_OUT
   } pdip_state_type;

   typedef struct packed {
      logic acc_rd;
      logic mul_lo;
      logic mul_xa;
      logic mul_xb;
      logic write_back;
      logic clear;
   } mac_ctrl_type;

endpackage

`default_nettype wire

// ===== rtl/core/pdip_channels.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pdip_channels
// Valid/ready channels for requests and answer words.
// ----------------------------------------------------------------------------
interface pdip_req_if import pdip_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic                  kind;
   logic [REC_IDX_W-1:0]  record_index;
   logic [WORD_IDX_W-1:0] word_index;
   logic [DATA_W-1:0]     value;

   modport source (output valid, kind, record_index, word_index, value, input ready);
   modport sink   (input valid, kind, record_index, word_index, value, output ready);
endinterface

interface pdip_rsp_if import pdip_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [WORD_IDX_W-1:0] answer_word_index;
   logic [DATA_W-1:0]     answer_value;
   logic                  last;

   modport source (output valid, answer_word_index, answer_value, last, input ready);
   modport sink   (input valid, answer_word_index, answer_value, last, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/pdip_record_store.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pdip_record_store
// Database word memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module pdip_record_store import pdip_pkg::*; #(
   parameter int DEPTH  = 8192,
   parameter int ADDR_W = 13
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [DATA_W-1:0] wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output      logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/core/pdip_mac_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pdip_mac_unit
// Shared 32x32 multiplier and 64-bit adder that build one word's product
// modulo 2^64 in three passes, with the per-word accumulator memory.
// ----------------------------------------------------------------------------
module pdip_mac_unit import pdip_pkg::*; #(
   parameter int RECORD_WORDS = 8,
   parameter int W_W          = 3
) (
   input  wire logic              clock,
   input  wire mac_ctrl_type      ctrl,
   input  wire logic [W_W-1:0]    acc_addr,
   input  wire logic [DATA_W-1:0] coef,
   input  wire logic [DATA_W-1:0] store_rdata,
   output      logic [DATA_W-1:0] acc_rdata
);

   logic [DATA_W-1:0] acc_ff [RECORD_WORDS];
   logic [DATA_W-1:0] acc_rdata_ff;
   logic [DATA_W-1:0] sum_ff;
   logic [DATA_W-1:0] sum_in;
   logic [DATA_W-1:0] prod_ff;
   logic [DATA_W-1:0] prod_in;
   logic [HALF_W-1:0] mul_a;
   logic [HALF_W-1:0] mul_b;
   logic [DATA_W-1:0] mul_p;
   logic [DATA_W-1:0] add_out;

   always_comb begin
      if (ctrl.mul_xb) begin
         mul_a = coef[DATA_W-1:HALF_W];
         mul_b = store_rdata[HALF_W-1:0];
      end else if (ctrl.mul_xa) begin
         mul_a = coef[HALF_W-1:0];
         mul_b = store_rdata[DATA_W-1:HALF_W];
      end else begin
         mul_a = coef[HALF_W-1:0];
         mul_b = store_rdata[HALF_W-1:0];
      end
   end

   assign mul_p   = DATA_W'(mul_a) * DATA_W'(mul_b);
   assign add_out = sum_ff + prod_ff;

   always_comb begin
      sum_in  = sum_ff;
      prod_in = prod_ff;
      if (ctrl.mul_lo) begin
         sum_in  = ctrl.clear ? '0 : acc_rdata_ff;
         prod_in = mul_p;
      end else if (ctrl.mul_xa || ctrl.mul_xb) begin
         sum_in  = add_out;
         prod_in = {mul_p[HALF_W-1:0], {HALF_W{1'b0}}};
      end
   end

   always_ff @(posedge clock) begin
      sum_ff  <= sum_in;
      prod_ff <= prod_in;
   end

   always_ff @(posedge clock) begin
      if (ctrl.write_back) begin
         acc_ff[acc_addr] <= add_out;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.acc_rd) begin
         acc_rdata_ff <= acc_ff[acc_addr];
      end
   end

   assign acc_rdata = acc_rdata_ff;

endmodule

`default_nettype wire

// ===== rtl/core/pdip_seq.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pdip_seq
// Sequencer: takes requests, steps the word loop through the shared unit,
// counts coefficients and drives the answer word register.
// ----------------------------------------------------------------------------
module pdip_seq import pdip_pkg::*; #(
   parameter int RECORD_WORDS    = 8,
   parameter int MAX_DOMAIN_BITS = 10,
   parameter int W_W             = 3,
   parameter int ADDR_W          = 13
) (
   input  wire logic                clock,
   input  wire logic                reset,
   pdip_req_if.sink                 req,
   pdip_rsp_if.source               rsp,
   input  wire logic                csr_we,
   input  wire logic [DOMAIN_W-1:0] csr_wdata,
   output      logic                store_wr_en,
   output      logic [ADDR_W-1:0]   store_wr_addr,
   output      logic                store_rd_en,
   output      logic [ADDR_W-1:0]   store_rd_addr,
   output      mac_ctrl_type        mac_ctrl,
   output      logic [W_W-1:0]      acc_addr,
   output      logic [DATA_W-1:0]   coef,
   input  wire logic [DATA_W-1:0]   acc_rdata
);

   localparam int NUM_RECORDS = 1 << MAX_DOMAIN_BITS;
   localparam int ROW_W       = MAX_DOMAIN_BITS;
   localparam int IDX_W       = MAX_DOMAIN_BITS + 1;

   pdip_state_type state_ff, state_in;

   logic [DOMAIN_W-1:0]   domain_ff;
   logic [IDX_W-1:0]      idx_ff;
   logic [ROW_W-1:0]      row_ff;
   logic [W_W-1:0]        w_ff;
   logic [DATA_W-1:0]     coef_ff;
   logic                  clear_ff;
   logic                  done_ff;
   logic                  rsp_valid_ff;
   logic [WORD_IDX_W-1:0] rsp_word_ff;
   logic [DATA_W-1:0]     rsp_value_ff;
   logic                  rsp_last_ff;

   logic [EFF_W-1:0]      eff_bits;
   logic [IDX_W-1:0]      size;
   logic [IDX_W-1:0]      idx_next;
   logic                  query_done;
   logic                  accept;
   logic                  load_ok;
   logic                  w_last;
   logic                  out_free;
   logic                  emit_load;

   always_comb begin
      if (domain_ff == '0) begin
         eff_bits = EFF_W'(1);
      end else if (EFF_W'(domain_ff) > EFF_W'(MAX_DOMAIN_BITS)) begin
         eff_bits = EFF_W'(MAX_DOMAIN_BITS);
      end else begin
         eff_bits = EFF_W'(domain_ff);
      end
   end

   assign size       = IDX_W'(1) << eff_bits;
   assign idx_next   = idx_ff + IDX_W'(1);
   assign query_done = idx_next >= size;
   assign accept     = req.valid && req.ready;
   assign load_ok    = (32'(req.record_index) < NUM_RECORDS)
                    && (32'(req.word_index) < RECORD_WORDS);
   assign w_last     = w_ff == W_W'(RECORD_WORDS - 1);
   assign out_free   = !rsp_valid_ff || rsp.ready;
   assign emit_load  = (state_ff == ST_EMIT_OUT) && out_free;

   assign store_wr_en   = accept && (req.kind == KIND_LOAD) && load_ok;
   assign store_wr_addr = ADDR_W'(ROW_W'(req.record_index)) * ADDR_W'(RECORD_WORDS)
                        + ADDR_W'(W_W'(req.word_index));
   assign store_rd_addr = ADDR_W'(row_ff) * ADDR_W'(RECORD_WORDS)
                        + ADDR_W'(w_ff);
   assign acc_addr      = w_ff;
   assign coef          = coef_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && (req.kind == KIND_COEF)) begin
               state_in = ST_FETCH;
            end
         end
         ST_FETCH:      state_in = ST_MUL_LO;
         ST_MUL_LO:     state_in = ST_MUL_XA;
         ST_MUL_XA:     state_in = ST_MUL_XB;
         ST_MUL_XB:     state_in = ST_WRITE_BACK;
         ST_WRITE_BACK: begin
            if (!w_last) begin
               state_in = ST_FETCH;
            end else if (done_ff) begin
               state_in = ST_EMIT_RD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_EMIT_RD:    state_in = ST_EMIT_OUT;
         ST_EMIT_OUT: begin
            if (out_free) begin
               state_in = w_last ? ST_IDLE : ST_EMIT_RD;
            end
         end
         default:       state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req.ready           = 1'b0;
      store_rd_en         = 1'b0;
      mac_ctrl            = '0;
      mac_ctrl.clear      = clear_ff;
      case (state_ff)
         ST_IDLE:       req.ready           = 1'b1;
         ST_FETCH: begin
            store_rd_en     = 1'b1;
            mac_ctrl.acc_rd = 1'b1;
         end
         ST_MUL_LO:     mac_ctrl.mul_lo     = 1'b1;
         ST_MUL_XA:     mac_ctrl.mul_xa     = 1'b1;
         ST_MUL_XB:     mac_ctrl.mul_xb     = 1'b1;
         ST_WRITE_BACK: mac_ctrl.write_back = 1'b1;
         ST_EMIT_RD:    mac_ctrl.acc_rd     = 1'b1;
         ST_EMIT_OUT:   ;
         default:       ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         domain_ff    <= DOMAIN_RESET;
         idx_ff       <= '0;
         w_ff         <= '0;
         clear_ff     <= 1'b0;
         done_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            domain_ff <= csr_wdata;
         end
         if (accept && (req.kind == KIND_COEF)) begin
            clear_ff <= idx_ff == '0;
            done_ff  <= query_done;
            idx_ff   <= query_done ? '0 : idx_next;
            w_ff     <= '0;
         end
         if (state_ff == ST_WRITE_BACK) begin
            w_ff <= w_last ? '0 : w_ff + W_W'(1);
         end
         if (emit_load) begin
            w_ff <= w_last ? '0 : w_ff + W_W'(1);
         end
         if (emit_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && (req.kind == KIND_COEF)) begin
         coef_ff <= req.value;
         row_ff  <= idx_ff[ROW_W-1:0];
      end
      if (emit_load) begin
         rsp_word_ff  <= WORD_IDX_W'(w_ff);
         rsp_value_ff <= acc_rdata;
         rsp_last_ff  <= w_last;
      end
   end

   assign rsp.valid             = rsp_valid_ff;
   assign rsp.answer_word_index = rsp_word_ff;
   assign rsp.answer_value      = rsp_value_ff;
   assign rsp.last              = rsp_last_ff;

endmodule

`default_nettype wire

// ===== rtl/core/pir_database_inner_product.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pir_database_inner_product
// Server side PIR read: records are loaded word by word, then a stream of
// coefficients forms per-word inner products modulo 2^64.
// ----------------------------------------------------------------------------
//  channel    direction  carries
//  req_chan   in         load word (kind 0) or next query coefficient (kind 1)
//  rsp_chan   out        answer words in word order, last on the final one
//  csr_*      in         domain size write
//
//  A coefficient takes, per word, one fetch, three passes through the
//  single 32x32 multiplier and one accumulator write. The final coefficient
//  then emits the answer words, each by an accumulator read and an output
//  load, while the output is taken. Synchronous reset clears control state
//  only; the record store needs no clearing pass. A stalled output holds
//  its word and halts the answer loop; once the final word sits in the
//  output register the next request can be taken.
// ----------------------------------------------------------------------------
module pir_database_inner_product import pdip_pkg::*; #(
   parameter int RECORD_WORDS    = 8,
   parameter int MAX_DOMAIN_BITS = 10
) (
   input  wire logic                clock,
   input  wire logic                reset,
   pdip_req_if.sink                 req_chan,
   pdip_rsp_if.source               rsp_chan,
   input  wire logic                csr_we,
   input  wire logic [DOMAIN_W-1:0] csr_wdata
);

   localparam int NUM_RECORDS = 1 << MAX_DOMAIN_BITS;
   localparam int DEPTH       = NUM_RECORDS * RECORD_WORDS;
   localparam int ADDR_W      = $clog2(DEPTH);
   localparam int W_W         = (RECORD_WORDS > 1) ? $clog2(RECORD_WORDS) : 1;

   logic              store_wr_en;
   logic [ADDR_W-1:0] store_wr_addr;
   logic              store_rd_en;
   logic [ADDR_W-1:0] store_rd_addr;
   logic [DATA_W-1:0] store_rdata;
   mac_ctrl_type      mac_ctrl;
   logic [W_W-1:0]    acc_addr;
   logic [DATA_W-1:0] coef;
   logic [DATA_W-1:0] acc_rdata;

   pdip_seq #(
      .RECORD_WORDS    (RECORD_WORDS),
      .MAX_DOMAIN_BITS (MAX_DOMAIN_BITS),
      .W_W             (W_W),
      .ADDR_W          (ADDR_W)
   ) u_seq (
      .clock         (clock),
      .reset         (reset),
      .req           (req_chan),
      .rsp           (rsp_chan),
      .csr_we        (csr_we),
      .csr_wdata     (csr_wdata),
      .store_wr_en   (store_wr_en),
      .store_wr_addr (store_wr_addr),
      .store_rd_en   (store_rd_en),
      .store_rd_addr (store_rd_addr),
      .mac_ctrl      (mac_ctrl),
      .acc_addr      (acc_addr),
      .coef          (coef),
      .acc_rdata     (acc_rdata)
   );

   pdip_record_store #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (store_wr_en),
      .wr_addr (store_wr_addr),
      .wr_data (req_chan.value),
      .rd_en   (store_rd_en),
      .rd_addr (store_rd_addr),
      .rd_data (store_rdata)
   );

   pdip_mac_unit #(
      .RECORD_WORDS (RECORD_WORDS),
      .W_W          (W_W)
   ) u_mac (
      .clock       (clock),
      .ctrl        (mac_ctrl),
      .acc_addr    (acc_addr),
      .coef        (coef),
      .store_rdata (store_rdata),
      .acc_rdata   (acc_rdata)
   );

endmodule

`default_nettype wire

// ===== tb/pdip_answer_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdip_answer_checker
// Watches the request, answer and register ports of the inner product block.
// It keeps its own copy of the record store, the per-word sums and the query
// position, and queues the answer words that each coefficient is due to
// produce. Each answer taken from the block is compared field by field with
// the oldest queued word.
// ----------------------------------------------------------------------------
module pdip_answer_checker import pdip_pkg::*; #(
   parameter int RECORD_WORDS    = 8,
   parameter int MAX_DOMAIN_BITS = 10
) (
   input  logic                clock,
   input  logic                reset,
   pdip_req_if                 req_mon,
   pdip_rsp_if                 rsp_mon,
   input  logic                csr_we,
   input  logic [DOMAIN_W-1:0] csr_wdata,
   output int                  mismatches,
   output int                  expected_left,
   output int                  answers_seen
);

   localparam int RECORDS = 1 << MAX_DOMAIN_BITS;

   typedef struct packed {
      logic [WORD_IDX_W-1:0] word;
      logic [DATA_W-1:0]     sum;
      logic                  last;
   } answer_word_type;

   logic [DATA_W-1:0]      db_words [RECORDS*RECORD_WORDS];
   logic [DATA_W-1:0]      word_sums [RECORD_WORDS];
   logic [MAX_DOMAIN_BITS:0] coef_pos;
   logic [DOMAIN_W-1:0]    query_log2;
   answer_word_type        answers_due [$];

   initial begin
      foreach (db_words[i]) db_words[i] = '0;
   end

   function automatic int records_in_domain(input logic [DOMAIN_W-1:0] bits);
      int eff;
      eff = int'(bits);
      if (eff < 1) eff = 1;
      if (eff > MAX_DOMAIN_BITS) eff = MAX_DOMAIN_BITS;
      return 1 << eff;
   endfunction

   task automatic accumulate_request(input logic kind, input logic [REC_IDX_W-1:0] rec,
                                     input logic [WORD_IDX_W-1:0] wrd,
                                     input logic [DATA_W-1:0] val);
      int row;
      answer_word_type aw;
      if (kind == KIND_LOAD) begin
         if (int'(rec) < RECORDS && int'(wrd) < RECORD_WORDS) begin
            db_words[int'(rec) * RECORD_WORDS + int'(wrd)] = val;
         end
         return;
      end
      if (coef_pos == 0) begin
         foreach (word_sums[w]) word_sums[w] = '0;
      end
      row = int'(coef_pos) % RECORDS;
      for (int w = 0; w < RECORD_WORDS; w++) begin
         word_sums[w] = word_sums[w] + val * db_words[row * RECORD_WORDS + w];
      end
      coef_pos = coef_pos + 1'b1;
      if (int'(coef_pos) < records_in_domain(query_log2)) return;
      coef_pos = '0;
      for (int w = 0; w < RECORD_WORDS; w++) begin
         aw.word = WORD_IDX_W'(w);
         aw.sum  = word_sums[w];
         aw.last = (w == RECORD_WORDS - 1);
         answers_due.push_back(aw);
      end
   endtask

   task automatic check_answer();
      answer_word_type aw;
      answers_seen++;
      if (answers_due.size() == 0) begin
         $error("unexpected answer: word %0d value %h last %0d",
                rsp_mon.answer_word_index, rsp_mon.answer_value, rsp_mon.last);
         mismatches++;
         return;
      end
      aw = answers_due.pop_front();
      if (rsp_mon.answer_word_index !== aw.word) begin
         $error("answer_word_index: expected %0d, got %0d", aw.word,
                rsp_mon.answer_word_index);
         mismatches++;
      end
      if (rsp_mon.answer_value !== aw.sum) begin
         $error("answer_value: expected %h, got %h", aw.sum, rsp_mon.answer_value);
         mismatches++;
      end
      if (rsp_mon.last !== aw.last) begin
         $error("last: expected %0d, got %0d", aw.last, rsp_mon.last);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         answers_due.delete();
         foreach (word_sums[w]) word_sums[w] = '0;
         coef_pos   = '0;
         query_log2 = DOMAIN_RESET;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) check_answer();
         if (req_mon.valid && req_mon.ready) begin
            accumulate_request(req_mon.kind, req_mon.record_index, req_mon.word_index,
                               req_mon.value);
         end
         if (csr_we) query_log2 = csr_wdata;
      end
      expected_left <= answers_due.size();
   end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the PIR database inner product block. The records
// that queries touch are loaded first, then short queries at the reset,
// saturated, zero and shrunk domains, directed cases and random mixes of
// loads, coefficients and domain changes run under three idling patterns,
// one of them with a long hold-off on the answer side.
// ----------------------------------------------------------------------------
module tb;
   import pdip_pkg::*;

   localparam int RECORD_WORDS    = 8;
   localparam int MAX_DOMAIN_BITS = 10;
   localparam int RECORDS         = 1 << MAX_DOMAIN_BITS;
   localparam int QUERY_RECORDS   = 4;
   localparam int SETTLE_CYCLES   = 64;
   localparam int HOLD_CYCLES     = 400;
   localparam int WATCHDOG_LIMIT  = 4000;
   localparam int PHASE_ITEMS     = 25;

   logic                clock;
   logic                reset;
   logic                csr_we;
   logic [DOMAIN_W-1:0] csr_wdata;

   int mismatches;
   int expected_left;
   int answers_seen;
   int req_idle_pct  = 38;
   int rsp_idle_pct  = 46;
   int hold_requests = 0;
   int loads_sent    = 0;
   int coefs_sent    = 0;
   int domain_writes = 0;
   int quiet_cycles  = 0;

   pdip_req_if req_if ();
   pdip_rsp_if rsp_if ();

   pir_database_inner_product #(
      .RECORD_WORDS    (RECORD_WORDS),
      .MAX_DOMAIN_BITS (MAX_DOMAIN_BITS)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_if),
      .rsp_chan  (rsp_if),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   pdip_answer_checker #(
      .RECORD_WORDS    (RECORD_WORDS),
      .MAX_DOMAIN_BITS (MAX_DOMAIN_BITS)
   ) checker_i (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_if),
      .rsp_mon       (rsp_if),
      .csr_we        (csr_we),
      .csr_wdata     (csr_wdata),
      .mismatches    (mismatches),
      .expected_left (expected_left),
      .answers_seen  (answers_seen)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // answer side: random stalls, plus one long hold-off on request
   initial begin
      int holds_done;
      holds_done = 0;
      rsp_if.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_requests != holds_done) begin
            holds_done++;
            rsp_if.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else if ($urandom_range(99) < rsp_idle_pct) begin
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: watchdog expired after %0d quiet cycles", quiet_cycles);
            $display("tb: FAIL");
            $finish;
         end
      end
   end

   function automatic logic [DATA_W-1:0] random_value();
      case ($urandom_range(7))
         0: return '0;
         1: return '1;
         2: return 64'd1;
         3: return {1'b1, 63'd0};
         default: return {$urandom, $urandom};
      endcase
   endfunction

   task automatic send_request(input logic kind, input logic [REC_IDX_W-1:0] rec,
                               input logic [WORD_IDX_W-1:0] wrd,
                               input logic [DATA_W-1:0] val);
      while ($urandom_range(99) < req_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid        <= 1'b1;
      req_if.kind         <= kind;
      req_if.record_index <= rec;
      req_if.word_index   <= wrd;
      req_if.value        <= val;
      do @(posedge clock); while (!req_if.ready);
      if (kind == KIND_LOAD) loads_sent++;
      else coefs_sent++;
   endtask

   task automatic run_query(input int count);
      repeat (count) begin
         send_request(KIND_COEF, REC_IDX_W'($urandom), WORD_IDX_W'($urandom),
                      random_value());
      end
   endtask

   // drop valid, wait for every answer, then let a coefficient in flight finish
   task automatic settle();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (expected_left != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_domain(input logic [DOMAIN_W-1:0] bits);
      settle();
      csr_we    <= 1'b1;
      csr_wdata <= bits;
      @(posedge clock);
      csr_we <= 1'b0;
      domain_writes++;
   endtask

   task automatic random_phase(input int items);
      int sent;
      int roll;
      sent = 0;
      while (sent < items) begin
         roll = $urandom_range(99);
         if (roll < 8) begin
            write_domain(DOMAIN_W'($urandom_range(2)));
         end else if (roll < 33) begin
            send_request(KIND_LOAD, REC_IDX_W'($urandom_range(RECORDS - 1)),
                         WORD_IDX_W'($urandom_range(RECORD_WORDS - 1)), random_value());
            sent++;
         end else begin
            run_query(1);
            sent++;
         end
      end
   endtask

   initial begin
      reset               = 1'b1;
      csr_we              = 1'b0;
      csr_wdata           = '0;
      req_if.valid        = 1'b0;
      req_if.kind         = KIND_LOAD;
      req_if.record_index = '0;
      req_if.word_index   = '0;
      req_if.value        = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // fill the records that every query below stays within
      for (int r = 0; r < QUERY_RECORDS; r++) begin
         for (int w = 0; w < RECORD_WORDS; w++) begin
            send_request(KIND_LOAD, REC_IDX_W'(r), WORD_IDX_W'(w), random_value());
         end
      end

      // start at the reset domain, shrink it to end on the current position
      run_query(3);
      write_domain(DOMAIN_W'(2));
      run_query(1);

      write_domain(DOMAIN_W'(1));
      send_request(KIND_LOAD, '0, '0, '1);
      send_request(KIND_LOAD, '0, WORD_IDX_W'(7), '0);
      send_request(KIND_LOAD, REC_IDX_W'(1), '0, 64'd1);
      send_request(KIND_LOAD, REC_IDX_W'(1), WORD_IDX_W'(7), {1'b1, 63'd0});
      send_request(KIND_LOAD, '1, WORD_IDX_W'(7), '1);
      send_request(KIND_LOAD, '1, '0, '0);
      send_request(KIND_COEF, '0, '0, '1);
      send_request(KIND_COEF, '1, '1, 64'd1);
      send_request(KIND_COEF, '1, '0, '0);
      send_request(KIND_COEF, '0, '1, {1'b1, 63'd0});

      // domain 0 acts as 1
      write_domain('0);
      run_query(2);

      // load lands between coefficients of a running query
      send_request(KIND_COEF, '0, '0, random_value());
      send_request(KIND_LOAD, REC_IDX_W'(1), WORD_IDX_W'(3), '1);
      send_request(KIND_COEF, '0, '0, '1);

      // above the maximum acts as the maximum, then shrink below the position
      write_domain('1);
      run_query(3);
      write_domain(DOMAIN_W'(1));
      run_query(1);

      random_phase(PHASE_ITEMS);

      req_idle_pct = 46;
      rsp_idle_pct <= 38;
      random_phase(PHASE_ITEMS);

      req_idle_pct = 0;
      rsp_idle_pct <= 0;
      write_domain(DOMAIN_W'(1));
      hold_requests <= hold_requests + 1;
      random_phase(PHASE_ITEMS);

      settle();
      $display("tb: %0d loads, %0d coefficients, %0d domain writes (0, 1, 2, 15 and reset)",
               loads_sent, coefs_sent, domain_writes);
      $display("tb: %0d answer words compared, one %0d-cycle answer hold-off",
               answers_seen, HOLD_CYCLES);
      if (mismatches == 0 && expected_left == 0) begin
         $display("tb: PASS");
      end else begin
         $display("tb: FAIL");
      end
      $finish;
   end

endmodule
